[rtl/hgm_pkg.sv]
package hgm_pkg;

  localparam int MAX_GROUP_DEF   = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int GW_REG_BITS     = 5;
  localparam int WIDTH_REG_BITS  = 13;
  localparam int HEIGHT_REG_BITS = 12;
  localparam int CFG_DATA_BITS   = 13;
  localparam int CFG_INDEX_BITS  = 2;

  localparam int COL_BITS   = 12;
  localparam int GROUP_BITS = 12;
  localparam int ROW_BITS   = 11;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 2048;

  localparam logic [GW_REG_BITS-1:0]     GW_RESET     = 5'd7;
  localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 13'd1024;
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 12'd512;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_GROUP_WIDTH  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } hgm_cfg_idx_e;

  typedef struct packed {
    logic [GROUP_BITS-1:0] group_index;
    logic [ROW_BITS-1:0]   row_from_bottom;
  } hgm_tag_t;

  typedef struct packed {
    logic     emit;
    hgm_tag_t tag;
  } hgm_step_t;

endpackage

[rtl/horizontal_group_median.sv]
// Horizontal group median over a raster of disparity pixels.
// Pixels enter on the in_* channel in row order, one transfer per cycle at
// most. Each row is cut into groups of group_width pixels; the last pixel of
// a complete group produces one result on the out_* channel: the upper
// median of the group, its index in the row and the row counted from the
// bottom. Pixels left over at the end of a row produce nothing.
// The result of a group passes the stage-1 register and then the output
// register. Throughput: one pixel per cycle while in_ready_o is high, set by
// the sample chain, which shifts and ranks one new pixel on each transfer.
// The configuration channel (cfg_*) is always ready; indexes 0..2 select
// group_width, image_width and image_height. Write it only while idle.
// Reset clears all counters and loads group_width 7, image_width 1024 and
// image_height 512. A stalled receiver holds the output register; one more
// result can wait behind it, after which in_ready_o drops until the
// receiver takes a transfer.
module horizontal_group_median #(
  parameter int MAX_GROUP   = hgm_pkg::MAX_GROUP_DEF,
  parameter int SAMPLE_BITS = hgm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]      pixel_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]      median_value_o,
  output logic [hgm_pkg::GROUP_BITS-1:0]     group_index_o,
  output logic [hgm_pkg::ROW_BITS-1:0]       row_from_bottom_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hgm_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [hgm_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  localparam int IDXW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CNTW = $clog2(MAX_GROUP + 1);

  logic                          in_fire;
  logic [CNTW-1:0]               fill_cnt, fill_inc, group_width;
  hgm_pkg::hgm_step_t            step;
  hgm_pkg::hgm_tag_t             out_tag;

  logic signed [SAMPLE_BITS-1:0] src_value [MAX_GROUP];
  logic [IDXW-1:0]               src_idx   [MAX_GROUP];
  logic [MAX_GROUP-1:0]          src_vec   [MAX_GROUP];
  logic [MAX_GROUP-1:0]          le_hot    [MAX_GROUP];
  logic [MAX_GROUP-1:0]          new_vec;

  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  hgm_frame_ctrl #(
    .MAX_GROUP (MAX_GROUP),
    .CNTW      (CNTW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .step_i        (in_fire),
    .fill_o        (fill_cnt),
    .fill_inc_o    (fill_inc),
    .group_width_o (group_width),
    .step_o        (step)
  );

  always_comb begin
    new_vec = '0;
    for (int p = 0; p < MAX_GROUP; p++) begin
      new_vec = new_vec | le_hot[p];
    end
  end

  assign src_value[0] = pixel_value_i;
  assign src_idx[0]   = IDXW'(fill_cnt);
  assign src_vec[0]   = new_vec;

  for (genvar p = 0; p < MAX_GROUP; p++) begin : g_cell
    if (p < MAX_GROUP - 1) begin : g_link
      hgm_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_GROUP   (MAX_GROUP),
        .IDXW        (IDXW)
      ) u_cell (
        .clk_i       (clk_i),
        .shift_i     (in_fire),
        .sample_i    (pixel_value_i),
        .new_idx_i   (IDXW'(fill_cnt)),
        .member_i    (CNTW'(p) < fill_cnt),
        .in_value_i  (src_value[p]),
        .in_idx_i    (src_idx[p]),
        .in_vec_i    (src_vec[p]),
        .out_value_o (src_value[p+1]),
        .out_idx_o   (src_idx[p+1]),
        .out_vec_o   (src_vec[p+1]),
        .le_hot_o    (le_hot[p])
      );
    end else begin : g_tail
      hgm_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_GROUP   (MAX_GROUP),
        .IDXW        (IDXW)
      ) u_cell (
        .clk_i       (clk_i),
        .shift_i     (in_fire),
        .sample_i    (pixel_value_i),
        .new_idx_i   (IDXW'(fill_cnt)),
        .member_i    (CNTW'(p) < fill_cnt),
        .in_value_i  (src_value[p]),
        .in_idx_i    (src_idx[p]),
        .in_vec_i    (src_vec[p]),
        .out_value_o (),
        .out_idx_o   (),
        .out_vec_o   (),
        .le_hot_o    (le_hot[p])
      );
    end
  end

  hgm_median_sel #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_GROUP   (MAX_GROUP),
    .IDXW        (IDXW),
    .CNTW        (CNTW)
  ) u_sel (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (in_fire && step.emit),
    .cand_value_i   (src_value),
    .cand_idx_i     (src_idx),
    .cand_vec_i     (src_vec),
    .fill_new_i     (fill_inc),
    .group_width_i  (group_width),
    .tag_i          (step.tag),
    .ready_o        (in_ready_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .median_value_o (median_value_o),
    .tag_o          (out_tag)
  );

  assign group_index_o     = out_tag.group_index;
  assign row_from_bottom_o = out_tag.row_from_bottom;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_cnt < CNTW'(MAX_GROUP))
    else $error("group fill count reached the chain length");

  a_stall_only_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while the output side could move");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && step.emit) |=> ##1 out_valid_o)
    else $error("completed group produced no result");

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && step.emit) |-> (fill_inc >= group_width && group_width != '0))
    else $error("group closed before it was full");

endmodule

[rtl/hgm_cell.sv]
module hgm_cell #(
  parameter int SAMPLE_BITS = hgm_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_GROUP   = hgm_pkg::MAX_GROUP_DEF,
  parameter int IDXW        = 4
) (
  input  logic                          clk_i,
  input  logic                          shift_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [IDXW-1:0]               new_idx_i,
  input  logic                          member_i,
  input  logic signed [SAMPLE_BITS-1:0] in_value_i,
  input  logic [IDXW-1:0]               in_idx_i,
  input  logic [MAX_GROUP-1:0]          in_vec_i,
  output logic signed [SAMPLE_BITS-1:0] out_value_o,
  output logic [IDXW-1:0]               out_idx_o,
  output logic [MAX_GROUP-1:0]          out_vec_o,
  output logic [MAX_GROUP-1:0]          le_hot_o
);

  logic signed [SAMPLE_BITS-1:0] value_q, value_d;
  logic [IDXW-1:0]               idx_q, idx_d;
  logic [MAX_GROUP-1:0]          vec_q, vec_d;
  logic                          lt;

  // vec bit j: sample with arrival index j sorts ahead of this one
  assign lt = sample_i < value_q;

  always_comb begin
    out_value_o = value_q;
    out_idx_o   = idx_q;
    out_vec_o   = vec_q;
    le_hot_o    = '0;
    if (member_i && lt) begin
      out_vec_o = vec_q | (MAX_GROUP'(1) << new_idx_i);
    end
    if (member_i && !lt) begin
      le_hot_o = MAX_GROUP'(1) << idx_q;
    end
  end

  always_comb begin
    value_d = value_q;
    idx_d   = idx_q;
    vec_d   = vec_q;
    if (shift_i) begin
      value_d = in_value_i;
      idx_d   = in_idx_i;
      vec_d   = in_vec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    idx_q   <= idx_d;
    vec_q   <= vec_d;
  end

endmodule

[rtl/hgm_frame_ctrl.sv]
module hgm_frame_ctrl #(
  parameter int MAX_GROUP = hgm_pkg::MAX_GROUP_DEF,
  parameter int CNTW      = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [hgm_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [hgm_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                step_i,
  output logic [CNTW-1:0]                     fill_o,
  output logic [CNTW-1:0]                     fill_inc_o,
  output logic [CNTW-1:0]                     group_width_o,
  output hgm_pkg::hgm_step_t                  step_o
);

  localparam logic [hgm_pkg::GW_REG_BITS:0]       GW_MAX = (hgm_pkg::GW_REG_BITS+1)'(MAX_GROUP);
  localparam logic [hgm_pkg::WIDTH_REG_BITS-1:0]  W_MAX  =
    hgm_pkg::WIDTH_REG_BITS'(hgm_pkg::MAX_WIDTH);
  localparam logic [hgm_pkg::HEIGHT_REG_BITS-1:0] H_MAX  =
    hgm_pkg::HEIGHT_REG_BITS'(hgm_pkg::MAX_HEIGHT);

  logic [hgm_pkg::GW_REG_BITS-1:0]     gw_q, gw_d;
  logic [hgm_pkg::WIDTH_REG_BITS-1:0]  width_q, width_d;
  logic [hgm_pkg::HEIGHT_REG_BITS-1:0] height_q, height_d;

  logic [CNTW-1:0]                fill_q, fill_d;
  logic [hgm_pkg::COL_BITS-1:0]   col_q, col_d;
  logic [hgm_pkg::GROUP_BITS-1:0] grp_q, grp_d;
  logic [hgm_pkg::ROW_BITS-1:0]   row_q, row_d;

  logic [CNTW-1:0]                     gw_eff;
  logic [hgm_pkg::WIDTH_REG_BITS-1:0]  w_eff;
  logic [hgm_pkg::HEIGHT_REG_BITS-1:0] h_eff;
  logic [CNTW-1:0]                     fill_inc;
  logic                                emit;
  logic [hgm_pkg::COL_BITS:0]          col_inc;
  logic                                row_end;
  logic [hgm_pkg::ROW_BITS-1:0]        row_inc;
  logic [hgm_pkg::HEIGHT_REG_BITS-1:0] rfb;

  always_comb begin
    gw_d     = gw_q;
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hgm_pkg::CFG_GROUP_WIDTH:  gw_d     = cfg_data_i[hgm_pkg::GW_REG_BITS-1:0];
        hgm_pkg::CFG_IMAGE_WIDTH:  width_d  = cfg_data_i[hgm_pkg::WIDTH_REG_BITS-1:0];
        hgm_pkg::CFG_IMAGE_HEIGHT: height_d = cfg_data_i[hgm_pkg::HEIGHT_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (gw_q == '0) begin
      gw_eff = CNTW'(1);
    end else if ({1'b0, gw_q} > GW_MAX) begin
      gw_eff = CNTW'(MAX_GROUP);
    end else begin
      gw_eff = CNTW'(gw_q);
    end
    if (width_q == '0) begin
      w_eff = hgm_pkg::WIDTH_REG_BITS'(1);
    end else if (width_q > W_MAX) begin
      w_eff = W_MAX;
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = hgm_pkg::HEIGHT_REG_BITS'(1);
    end else if (height_q > H_MAX) begin
      h_eff = H_MAX;
    end else begin
      h_eff = height_q;
    end
  end

  assign fill_inc = fill_q + CNTW'(1);
  assign emit     = fill_inc >= gw_eff;
  assign col_inc  = {1'b0, col_q} + (hgm_pkg::COL_BITS+1)'(1);
  assign row_end  = col_inc >= w_eff;
  assign row_inc  = row_q + hgm_pkg::ROW_BITS'(1);
  assign rfb      = h_eff - hgm_pkg::HEIGHT_REG_BITS'(1) - {1'b0, row_q};

  always_comb begin
    fill_d = fill_q;
    col_d  = col_q;
    grp_d  = grp_q;
    row_d  = row_q;
    if (step_i) begin
      fill_d = emit ? '0 : fill_inc;
      grp_d  = emit ? grp_q + hgm_pkg::GROUP_BITS'(1) : grp_q;
      col_d  = col_inc[hgm_pkg::COL_BITS-1:0];
      if (row_end) begin
        fill_d = '0;
        grp_d  = '0;
        col_d  = '0;
        row_d  = ({1'b0, row_inc} >= h_eff) ? '0 : row_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q     <= hgm_pkg::GW_RESET;
      width_q  <= hgm_pkg::WIDTH_RESET;
      height_q <= hgm_pkg::HEIGHT_RESET;
      fill_q   <= '0;
      col_q    <= '0;
      grp_q    <= '0;
      row_q    <= '0;
    end else begin
      gw_q     <= gw_d;
      width_q  <= width_d;
      height_q <= height_d;
      fill_q   <= fill_d;
      col_q    <= col_d;
      grp_q    <= grp_d;
      row_q    <= row_d;
    end
  end

  assign fill_o                     = fill_q;
  assign fill_inc_o                 = fill_inc;
  assign group_width_o              = gw_eff;
  assign step_o.emit                = emit;
  assign step_o.tag.group_index     = grp_q;
  assign step_o.tag.row_from_bottom = rfb[hgm_pkg::ROW_BITS-1:0];

endmodule

[rtl/hgm_median_sel.sv]
module hgm_median_sel #(
  parameter int SAMPLE_BITS = hgm_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_GROUP   = hgm_pkg::MAX_GROUP_DEF,
  parameter int IDXW        = 4,
  parameter int CNTW        = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic signed [SAMPLE_BITS-1:0] cand_value_i [MAX_GROUP],
  input  logic [IDXW-1:0]               cand_idx_i   [MAX_GROUP],
  input  logic [MAX_GROUP-1:0]          cand_vec_i   [MAX_GROUP],
  input  logic [CNTW-1:0]               fill_new_i,
  input  logic [CNTW-1:0]               group_width_i,
  input  hgm_pkg::hgm_tag_t             tag_i,
  output logic                          ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] median_value_o,
  output hgm_pkg::hgm_tag_t             tag_o
);

  logic                          s1_valid_q, s1_valid_d;
  logic signed [SAMPLE_BITS-1:0] s1_val_q [MAX_GROUP];
  logic [MAX_GROUP-1:0]          s1_vec_q [MAX_GROUP];
  logic [MAX_GROUP-1:0]          s1_incl_q;
  logic [CNTW-1:0]               s1_half_q;
  hgm_pkg::hgm_tag_t             s1_tag_q;

  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] out_med_q;
  hgm_pkg::hgm_tag_t             out_tag_q;

  logic [MAX_GROUP-1:0]          gw_mask;
  logic [MAX_GROUP-1:0]          incl;
  logic signed [SAMPLE_BITS-1:0] med;
  logic                          out_free, s1_adv;

  assign out_free = !out_valid_q || out_ready_i;
  assign s1_adv   = s1_valid_q && out_free;
  assign ready_o  = !s1_valid_q || s1_adv;

  // keep only the first group_width arrivals of the group
  always_comb begin
    for (int j = 0; j < MAX_GROUP; j++) begin
      gw_mask[j] = CNTW'(j) < group_width_i;
      incl[j]    = (CNTW'(j) < fill_new_i) && (CNTW'(cand_idx_i[j]) < group_width_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int p = 0; p < MAX_GROUP; p++) begin
        s1_val_q[p] <= cand_value_i[p];
        s1_vec_q[p] <= cand_vec_i[p] & gw_mask;
      end
      s1_incl_q <= incl;
      s1_half_q <= group_width_i >> 1;
      s1_tag_q  <= tag_i;
    end
  end

  // ranks among the kept samples are distinct, exactly one matches
  always_comb begin
    med = '0;
    for (int p = 0; p < MAX_GROUP; p++) begin
      if (s1_incl_q[p] && (CNTW'($countones(s1_vec_q[p])) == s1_half_q)) begin
        med = med | s1_val_q[p];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_med_q <= med;
      out_tag_q <= s1_tag_q;
    end
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (load_i) begin
      s1_valid_d = 1'b1;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign median_value_o = out_med_q;
  assign tag_o          = out_tag_q;

endmodule

[test/horizontal_group_median_tb.sv]
`timescale 1ns / 100ps

module horizontal_group_median_tb;

  typedef struct {
    logic signed [15:0] median;
    logic [11:0]        group_idx;
    logic [10:0]        row_bottom;
  } median_result_t;

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               in_valid_i        = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] pixel_value_i     = '0;
  logic               out_valid_o;
  logic               out_ready_i       = 1'b0;
  logic signed [15:0] median_value_o;
  logic [hgm_pkg::GROUP_BITS-1:0] group_index_o;
  logic [hgm_pkg::ROW_BITS-1:0]   row_from_bottom_o;
  logic               cfg_valid_i       = 1'b0;
  logic               cfg_ready_o;
  logic [hgm_pkg::CFG_INDEX_BITS-1:0] cfg_index_i = hgm_pkg::CFG_GROUP_WIDTH;
  logic [hgm_pkg::CFG_DATA_BITS-1:0]  cfg_data_i  = '0;

  // predictor state
  logic [4:0]         gw_cfg;
  logic [12:0]        iw_cfg;
  logic [11:0]        ih_cfg;
  logic signed [15:0] group_buf [16];
  int unsigned        fill;
  logic [12:0]        col;
  logic [11:0]        grp;
  logic [10:0]        row;

  median_result_t     median_q [$];
  median_result_t     want;
  int unsigned        sender_idle_pct    = 0;
  int unsigned        receiver_stall_pct = 0;
  int unsigned        mismatches         = 0;
  int unsigned        pixels_sent        = 0;
  int unsigned        medians_checked    = 0;
  int unsigned        medians_predicted  = 0;
  int unsigned        reg_writes         = 0;

  horizontal_group_median DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pixel_value_i    (pixel_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .median_value_o   (median_value_o),
    .group_index_o    (group_index_o),
    .row_from_bottom_o(row_from_bottom_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  function automatic int unsigned group_size();
    if (gw_cfg == 0) return 1;
    if (gw_cfg > 16) return 16;
    return 32'(gw_cfg);
  endfunction

  function automatic int unsigned row_length();
    if (iw_cfg == 0) return 1;
    if (iw_cfg > 4096) return 4096;
    return 32'(iw_cfg);
  endfunction

  function automatic int unsigned frame_rows();
    if (ih_cfg == 0) return 1;
    if (ih_cfg > 2048) return 2048;
    return 32'(ih_cfg);
  endfunction

  // upper median of the first n samples of the group
  function automatic logic signed [15:0] median_of(input int unsigned n);
    logic signed [15:0] srt [16];
    logic signed [15:0] x;
    int j;
    for (int i = 0; i < n; i++) begin
      x = group_buf[i];
      j = i;
      while (j > 0 && srt[j-1] > x) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = x;
    end
    return srt[n/2];
  endfunction

  function automatic void track_pixel(input logic signed [15:0] v);
    int unsigned    g;
    median_result_t r;
    g = group_size();
    if (fill < 16) group_buf[fill] = v;
    fill++;
    if (fill >= g) begin
      r.median     = median_of(g);
      r.group_idx  = grp;
      r.row_bottom = 11'(frame_rows() - 1 - row);
      median_q = {median_q, r};
      medians_predicted++;
      grp  = grp + 12'd1;
      fill = 0;
    end
    col = col + 13'd1;
    if (col >= row_length()) begin
      col  = '0;
      fill = 0;
      grp  = '0;
      row  = row + 11'd1;
      if (row >= frame_rows()) row = '0;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (median_q.size() == 0) begin
        $error("result with nothing pending: median %0d group %0d row %0d",
               median_value_o, group_index_o, row_from_bottom_o);
        mismatches++;
      end else begin
        want = median_q.pop_front();
        medians_checked++;
        if (median_value_o !== want.median) begin
          $error("median_value: expected %0d, got %0d", want.median, median_value_o);
          mismatches++;
        end
        if (group_index_o !== want.group_idx) begin
          $error("group_index: expected %0d, got %0d", want.group_idx, group_index_o);
          mismatches++;
        end
        if (row_from_bottom_o !== want.row_bottom) begin
          $error("row_from_bottom: expected %0d, got %0d", want.row_bottom,
                 row_from_bottom_o);
          mismatches++;
        end
      end
    end
  end

  task automatic send_pixel(input logic signed [15:0] v);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_value_i <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    track_pixel(v);
    pixels_sent++;
  endtask

  // stop sending, let every pending median drain, then let the pipe settle
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (median_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input hgm_pkg::hgm_cfg_idx_e idx, input logic [12:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      hgm_pkg::CFG_GROUP_WIDTH:  gw_cfg = data[4:0];
      hgm_pkg::CFG_IMAGE_WIDTH:  iw_cfg = data;
      hgm_pkg::CFG_IMAGE_HEIGHT: ih_cfg = data[11:0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [12:0] gw, input logic [12:0] iw,
                              input logic [12:0] ih);
    settle_idle();
    write_reg(hgm_pkg::CFG_GROUP_WIDTH, gw);
    write_reg(hgm_pkg::CFG_IMAGE_WIDTH, iw);
    write_reg(hgm_pkg::CFG_IMAGE_HEIGHT, ih);
  endtask

  function automatic logic signed [15:0] random_pixel();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      1, 2: return 16'($signed($urandom_range(0, 7)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // reset values, one group of extreme samples
  task automatic test_defaults();
    send_pixel(16'sh7FFF);
    send_pixel(16'sh8000);
    send_pixel(16'shFFFF);
    send_pixel(16'sh0000);
    send_pixel(16'sh0001);
    send_pixel(16'sh7FFE);
    send_pixel(16'sh8001);
  endtask

  // zero group width, row shrunk below the current column, two-row frame
  task automatic test_degenerate_sizes();
    set_geometry(13'd0, 13'd3, 13'd2);
    for (int i = 0; i < 6; i++) send_pixel(random_pixel());
  endtask

  // saturated registers, then group width cut below the fill of an open group
  task automatic test_group_shrink();
    set_geometry(13'd31, 13'd8191, 13'd4095);
    for (int i = 0; i < 5; i++) send_pixel(random_pixel());
    settle_idle();
    write_reg(hgm_pkg::CFG_GROUP_WIDTH, 13'd2);
    send_pixel(16'sh0123);
    send_pixel(16'sh8000);
    send_pixel(16'sh7FFF);
  endtask

  task automatic test_random_phases();
    logic [12:0] gw, iw, ih;
    int unsigned base;
    int phase;
    base  = medians_predicted;
    phase = 0;
    while (phase < 8 || (medians_predicted - base < 60 && phase < 16)) begin
      case (phase)
        1: begin gw = 13'd1; iw = 13'd0; ih = 13'd0; end
        2: begin gw = 13'd16; iw = 13'd4096; ih = 13'd2048; end
        default: begin
          case ($urandom_range(0, 9))
            0: gw = 13'd0;
            1: gw = 13'($urandom_range(17, 31));
            2: gw = 13'd16;
            default: gw = 13'($urandom_range(1, 16));
          endcase
          case ($urandom_range(0, 9))
            0: iw = 13'd0;
            1: iw = 13'd4096;
            2: iw = 13'($urandom_range(4097, 8191));
            3: iw = 13'($urandom_range(1, 4096));
            default: iw = 13'($urandom_range(1, 48));
          endcase
          case ($urandom_range(0, 9))
            0: ih = 13'd0;
            1: ih = 13'd2048;
            2: ih = 13'($urandom_range(2049, 4095));
            default: ih = 13'($urandom_range(1, 6));
          endcase
        end
      endcase
      set_geometry(gw, iw, ih);
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
        default: begin sender_idle_pct = 18; receiver_stall_pct = 18; end
      endcase
      for (int i = 0; i < 80; i++) begin
        if (i == 40) settle_idle();
        send_pixel(random_pixel());
      end
      phase++;
    end
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
  endtask

  initial begin
    int unsigned guard;
    gw_cfg = hgm_pkg::GW_RESET;
    iw_cfg = hgm_pkg::WIDTH_RESET;
    ih_cfg = hgm_pkg::HEIGHT_RESET;
    fill   = 0;
    col    = '0;
    grp    = '0;
    row    = '0;
    for (int i = 0; i < 16; i++) group_buf[i] = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_degenerate_sizes();
    test_group_shrink();
    test_random_phases();

    in_valid_i <= 1'b0;
    guard = 0;
    while (median_q.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (median_q.size() != 0) begin
      $error("%0d medians never arrived", median_q.size());
      mismatches++;
    end

    $display("%0d pixels, %0d medians checked, %0d register writes", pixels_sent,
             medians_checked, reg_writes);
    $display("group widths 1..16 and saturated, row and frame wrap, mid-group cut, stalls");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[horizontal_group_median.f]
rtl/hgm_pkg.sv
rtl/hgm_cell.sv
rtl/hgm_frame_ctrl.sv
rtl/hgm_median_sel.sv
rtl/horizontal_group_median.sv
test/horizontal_group_median_tb.sv
